>>> rtl/core/gmix_pkg.sv
package gmix_pkg;

	// Fixed field widths
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CMD_W      = 2;
	localparam int IDX_W      = 3;
	localparam int SAMPLE_W   = 32;
	localparam int GAIN_IN_W  = 16;
	localparam int FMT_W      = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_GAIN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOLO     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MUTE     = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNITY_MODE    = 3'd3;

	// Sample formats; any other code saturates as 32-bit
	localparam logic [FMT_W-1:0] FMT_S8  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SAMPLE_W+1:0] wide_t;

	// Saturate a widened sum to the selected sample format
	function automatic sample_t sat_format(input wide_t v, input logic [FMT_W-1:0] fmt);
		wide_t hi;
		wide_t lo;
		case (fmt)
			FMT_S8: begin
				hi = 34'sd127;
				lo = -34'sd128;
			end
			FMT_S16: begin
				hi = 34'sd32767;
				lo = -34'sd32768;
			end
			default: begin
				hi = 34'sd2147483647;
				lo = -34'sd2147483648;
			end
		endcase
		if (v > hi) begin
			return sample_t'(hi[SAMPLE_W-1:0]);
		end else if (v < lo) begin
			return sample_t'(lo[SAMPLE_W-1:0]);
		end
		return sample_t'(v[SAMPLE_W-1:0]);
	endfunction

endpackage

>>> rtl/core/gain_matrix_audio_mixer.sv
// Gain-matrix audio mixer with mute and solo.
// Input channel (in_valid / in_stall): one command per transaction: a source sample,
// a gain write, a solo toggle or a mute toggle, each optionally closing a frame.
// Output channel (out_valid / out_stall): one transaction per output channel at
// the end of a frame, channels in ascending order, last_of_frame on the final one.
// Configuration is a write-only port (cfg_wr_en, cfg_index, cfg_data); it is to be
// written while the mixer is idle, which the block itself does not enforce.
// Throughput: one input transaction per cycle while in_stall is low. All output multiplies for one
// sample run in parallel in stage 1 and the accumulate/saturate runs in stage 2.
// An end-of-frame transaction passes through stage 1, stage 2 and the frame buffer
// into the output register, then one channel per cycle while out_stall is low.
// A finished frame drains from a frame buffer, so mixing continues meanwhile; a
// second end of frame waits in stage 2 (in_stall high) until the buffer is empty.
// Reset clears gains, solo and mute flags, accumulators, and sets the registers
// to two outputs, two sources, 16-bit format, unity mode off. Nothing is emitted.
// While out_stall is high a valid output holds and the frame buffer stops draining.
module gain_matrix_audio_mixer #(
	parameter int MAX_SOURCES        = 8,
	parameter int MAX_OUTPUTS        = 8,
	parameter int GAIN_FRACTION_BITS = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [gmix_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gmix_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [gmix_pkg::CMD_W-1:0]         command,
	input  logic [gmix_pkg::IDX_W-1:0]         source_index,
	input  logic [gmix_pkg::IDX_W-1:0]         output_index,
	input  logic signed [gmix_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [gmix_pkg::GAIN_IN_W-1:0]     gain_value,
	input  logic                               end_of_frame,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [gmix_pkg::IDX_W-1:0]         channel,
	output logic signed [gmix_pkg::SAMPLE_W-1:0] mixed_sample,
	output logic                               last_of_frame
);
	import gmix_pkg::*;

	localparam int GFB    = GAIN_FRACTION_BITS;
	localparam int GW     = GFB + 1;
	localparam int WG     = (GW > GAIN_IN_W) ? GW : GAIN_IN_W;
	localparam int PW     = SAMPLE_W + GW;
	localparam int MAXN   = (MAX_SOURCES > MAX_OUTPUTS) ? MAX_SOURCES : MAX_OUTPUTS;
	localparam int CNT_W  = ($clog2(MAXN + 1) > CFG_W) ? $clog2(MAXN + 1) : CFG_W;
	localparam int SIDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int OIDX_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int SC_W   = $clog2(MAX_SOURCES + 1);
	localparam int SCL_W  = SAMPLE_W + 1;

	// Configuration registers
	logic [CFG_W-1:0] output_count_q;
	logic [CFG_W-1:0] source_count_q;
	logic [FMT_W-1:0] sample_format_q;
	logic             unity_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_count_q  <= CFG_W'(2);
			source_count_q  <= CFG_W'(2);
			sample_format_q <= FMT_S16;
			unity_mode_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OUTPUT_COUNT:  output_count_q  <= cfg_data;
				CFG_SOURCE_COUNT:  source_count_q  <= cfg_data;
				CFG_SAMPLE_FORMAT: sample_format_q <= cfg_data[FMT_W-1:0];
				CFG_UNITY_MODE:    unity_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Active counts, limited to the built sizes
	logic [CNT_W-1:0] nout;
	logic [CNT_W-1:0] nsrc;

	assign nout = (CNT_W'(output_count_q) > CNT_W'(MAX_OUTPUTS)) ?
		CNT_W'(MAX_OUTPUTS) : CNT_W'(output_count_q);
	assign nsrc = (CNT_W'(source_count_q) > CNT_W'(MAX_SOURCES)) ?
		CNT_W'(MAX_SOURCES) : CNT_W'(source_count_q);

	// Pipeline control: an end of frame in stage 2 waits for the frame buffer
	logic valid_s1;
	logic valid_s2;
	logic eof_s2;
	logic fb_busy_q;
	logic adv;

	assign adv      = !(valid_s2 && eof_s2 && fb_busy_q);
	assign in_stall = !adv;

	// Stage 1 input register
	logic [CMD_W-1:0] cmd_s1;
	logic [IDX_W-1:0] k_s1;
	logic [IDX_W-1:0] j_s1;
	sample_t          sample_s1;
	logic [GAIN_IN_W-1:0] gain_s1;
	logic             eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			cmd_s1    <= command;
			k_s1      <= source_index;
			j_s1      <= output_index;
			sample_s1 <= sample_value;
			gain_s1   <= gain_value;
			eof_s1    <= end_of_frame;
		end
	end

	// Stage 1 decode and index checks
	logic [7:0]        k_wide;
	logic [7:0]        j_wide;
	logic [SIDX_W-1:0] k_idx;
	logic [OIDX_W-1:0] ko_idx;
	logic [OIDX_W-1:0] j_idx;
	logic              k_in_src;
	logic              k_in_out;
	logic              j_in_out;
	logic              is_sample;
	logic              pass;
	logic              uni_we;
	logic              mix_go;

	logic [MAX_SOURCES-1:0] solo_q;
	logic [MAX_SOURCES-1:0] mute_q;
	logic [SC_W-1:0]        solo_cnt_q;

	assign k_wide    = 8'(k_s1);
	assign j_wide    = 8'(j_s1);
	assign k_idx     = k_wide[SIDX_W-1:0];
	assign ko_idx    = k_wide[OIDX_W-1:0];
	assign j_idx     = j_wide[OIDX_W-1:0];
	assign k_in_src  = CNT_W'(k_s1) < nsrc;
	assign k_in_out  = CNT_W'(k_s1) < nout;
	assign j_in_out  = CNT_W'(j_s1) < nout;
	assign is_sample = valid_s1 && (cmd_s1 == CMD_SAMPLE);
	assign pass      = (solo_cnt_q != '0) ? solo_q[k_idx] : !mute_q[k_idx];
	assign uni_we    = is_sample && unity_mode_q && k_in_out;
	assign mix_go    = is_sample && !unity_mode_q && k_in_src && pass;

	// Solo and mute flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solo_q     <= '0;
			mute_q     <= '0;
			solo_cnt_q <= '0;
		end else if (adv && valid_s1 && k_in_src) begin
			if (cmd_s1 == CMD_SOLO) begin
				solo_q[k_idx] <= !solo_q[k_idx];
				if (!solo_q[k_idx]) begin
					solo_cnt_q <= solo_cnt_q + SC_W'(1);
				end else if (solo_cnt_q != '0) begin
					solo_cnt_q <= solo_cnt_q - SC_W'(1);
				end
			end else if (cmd_s1 == CMD_MUTE) begin
				mute_q[k_idx] <= !mute_q[k_idx];
			end
		end
	end

	// Gain matrix: one row per output, each row read at the source index
	logic [GW-1:0] gain_q [MAX_OUTPUTS][MAX_SOURCES];
	logic [WG-1:0] gain_ext;
	logic [WG-1:0] unity_ext;
	logic [GW-1:0] gain_wr;

	assign gain_ext  = WG'(gain_s1);
	assign unity_ext = WG'(1) << GFB;
	assign gain_wr   = (gain_ext > unity_ext) ? GW'(unity_ext) : GW'(gain_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o < MAX_OUTPUTS; o++) begin
				for (int s = 0; s < MAX_SOURCES; s++) begin
					gain_q[o][s] <= '0;
				end
			end
		end else if (adv && valid_s1 && (cmd_s1 == CMD_SET_GAIN) && k_in_src && j_in_out) begin
			gain_q[j_idx][k_idx] <= gain_wr;
		end
	end

	// Stage 1 multiplies: |sample| * gain >> fraction bits, sign restored
	logic                 neg;
	logic [SAMPLE_W-1:0]  mag;
	logic [PW-1:0]        prod   [MAX_OUTPUTS];
	logic [SCL_W-1:0]     scaled [MAX_OUTPUTS];
	logic [MAX_OUTPUTS-1:0] mix_en;

	assign neg = sample_s1[SAMPLE_W-1];
	assign mag = neg ? (~sample_s1 + SAMPLE_W'(1)) : sample_s1;

	always_comb begin
		for (int o = 0; o < MAX_OUTPUTS; o++) begin
			prod[o]   = PW'(mag) * PW'(gain_q[o][k_idx]);
			scaled[o] = neg ? (~{1'b0, prod[o][GFB+SAMPLE_W-1:GFB]} + SCL_W'(1))
				: {1'b0, prod[o][GFB+SAMPLE_W-1:GFB]};
			mix_en[o] = mix_go && (CNT_W'(o) < nout);
		end
	end

	// Stage 2 register
	logic [SCL_W-1:0]       scaled_s2 [MAX_OUTPUTS];
	logic [MAX_OUTPUTS-1:0] mix_en_s2;
	logic                   uni_we_s2;
	logic [OIDX_W-1:0]      uni_idx_s2;
	sample_t                uni_val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			eof_s2     <= eof_s1;
			mix_en_s2  <= mix_en;
			uni_we_s2  <= uni_we;
			uni_idx_s2 <= ko_idx;
			uni_val_s2 <= sample_s1;
			for (int o = 0; o < MAX_OUTPUTS; o++) begin
				scaled_s2[o] <= scaled[o];
			end
		end
	end

	// Stage 2 accumulate and saturate
	sample_t acc_q   [MAX_OUTPUTS];
	sample_t acc_upd [MAX_OUTPUTS];
	sample_t snap    [MAX_OUTPUTS];
	logic    commit;
	logic    fb_load;

	assign commit  = valid_s2 && adv;
	assign fb_load = commit && eof_s2 && (nout != '0);

	always_comb begin
		for (int o = 0; o < MAX_OUTPUTS; o++) begin
			if (uni_we_s2 && (uni_idx_s2 == OIDX_W'(o))) begin
				acc_upd[o] = sat_format(wide_t'(uni_val_s2), sample_format_q);
			end else if (mix_en_s2[o]) begin
				acc_upd[o] = sat_format(wide_t'(acc_q[o]) + wide_t'($signed(scaled_s2[o])),
					sample_format_q);
			end else begin
				acc_upd[o] = acc_q[o];
			end
			snap[o] = sat_format(wide_t'(acc_upd[o]), sample_format_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o < MAX_OUTPUTS; o++) begin
				acc_q[o] <= '0;
			end
		end else if (commit) begin
			for (int o = 0; o < MAX_OUTPUTS; o++) begin
				acc_q[o] <= eof_s2 ? '0 : acc_upd[o];
			end
		end
	end

	// Frame buffer: holds a finished frame while it drains to the output
	sample_t          fb_q [MAX_OUTPUTS];
	logic [CNT_W-1:0] fb_ptr_q;
	logic [CNT_W-1:0] fb_cnt_q;
	logic             out_valid_q;
	logic             fb_pop;
	logic             fb_last;

	assign fb_pop  = fb_busy_q && (!out_valid_q || !out_stall);
	assign fb_last = (fb_ptr_q + CNT_W'(1)) == fb_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_busy_q <= 1'b0;
			fb_ptr_q  <= '0;
			fb_cnt_q  <= '0;
		end else if (fb_load) begin
			fb_busy_q <= 1'b1;
			fb_ptr_q  <= '0;
			fb_cnt_q  <= nout;
		end else if (fb_pop) begin
			fb_ptr_q <= fb_ptr_q + CNT_W'(1);
			if (fb_last) begin
				fb_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fb_load) begin
			for (int o = 0; o < MAX_OUTPUTS; o++) begin
				fb_q[o] <= snap[o];
			end
		end
	end

	// Output register
	logic [IDX_W-1:0] channel_q;
	sample_t          mixed_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fb_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fb_pop) begin
			channel_q <= fb_ptr_q[IDX_W-1:0];
			mixed_q   <= fb_q[fb_ptr_q[OIDX_W-1:0]];
			last_q    <= fb_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel       = channel_q;
	assign mixed_sample  = mixed_q;
	assign last_of_frame = last_q;

`ifndef SYNTHESIS
	// The drain pointer stays inside the frame it is emitting
	a_fb_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		fb_busy_q |-> (fb_ptr_q < fb_cnt_q))
		else $error("frame buffer pointer past frame length");

	// The solo count tracks the solo flags exactly
	a_solo_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(solo_q) == int'(solo_cnt_q))
		else $error("solo count out of step with solo flags");

	// A committed frame end with active outputs starts a drain from channel zero
	a_fb_start: assert property (@(posedge clk) disable iff (!arst_n)
		fb_load |=> (fb_busy_q && (fb_ptr_q == '0)))
		else $error("frame end did not start the frame buffer");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

import gmix_pkg::*;

localparam int GAIN_FRAC  = 15;
localparam int UNITY_GAIN = 1 << GAIN_FRAC;
localparam int LANES      = 8;

// Format codes the package leaves unnamed
localparam logic [FMT_W-1:0] FMT_S32       = 2'd2;
localparam logic [FMT_W-1:0] FMT_WIDE_CODE = 2'd3;

typedef struct {
	logic [IDX_W-1:0]    chan;
	logic [SAMPLE_W-1:0] value;
	logic                last;
} mix_result_t;

// Mirror of the mixer state plus the queue of channel outputs still owed
class mix_scoreboard;
	int unsigned n_out_cfg;
	int unsigned n_src_cfg;
	logic [FMT_W-1:0] fmt_cfg;
	logic unity_cfg;

	int unsigned gain_q15[LANES][LANES];
	bit solo_on[LANES];
	bit mute_on[LANES];
	int unsigned solo_total;
	longint acc[LANES];

	mix_result_t owed[$];
	int errors;

	function new();
		n_out_cfg = 2;
		n_src_cfg = 2;
		fmt_cfg = FMT_S16;
		unity_cfg = 1'b0;
		solo_total = 0;
		errors = 0;
		for (int o = 0; o < LANES; o++) begin
			acc[o] = 0;
			solo_on[o] = 1'b0;
			mute_on[o] = 1'b0;
			for (int s = 0; s < LANES; s++)
				gain_q15[o][s] = 0;
		end
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_OUTPUT_COUNT:  n_out_cfg = data;
			CFG_SOURCE_COUNT:  n_src_cfg = data;
			CFG_SAMPLE_FORMAT: fmt_cfg = data[FMT_W-1:0];
			CFG_UNITY_MODE:    unity_cfg = data[0];
			default: ;
		endcase
	endfunction

	function longint saturate(longint v);
		longint hi;
		longint lo;
		case (fmt_cfg)
			FMT_S8: begin
				hi = 127;
				lo = -128;
			end
			FMT_S16: begin
				hi = 32767;
				lo = -32768;
			end
			default: begin
				hi = 64'sd2147483647;
				lo = -64'sd2147483648;
			end
		endcase
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// sample * gain in Q15, truncated toward zero
	function longint apply_gain(longint s, int unsigned g);
		longint mag;
		longint p;
		mag = (s < 0) ? -s : s;
		p = (mag * longint'(g)) >>> GAIN_FRAC;
		return (s < 0) ? -p : p;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// Accepted input transaction: update the mirror, queue the frame outputs
	function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] k,
			logic [IDX_W-1:0] j, logic signed [SAMPLE_W-1:0] sample,
			logic [GAIN_IN_W-1:0] gain, logic eof);
		int unsigned nout;
		int unsigned nsrc;
		longint s;
		bit pass;
		mix_result_t r;
		nout = (n_out_cfg > LANES) ? LANES : n_out_cfg;
		nsrc = (n_src_cfg > LANES) ? LANES : n_src_cfg;
		s = sample;
		case (cmd)
			CMD_SAMPLE: begin
				if (unity_cfg) begin
					if (k < nout)
						acc[k] = saturate(s);
				end else if (k < nsrc) begin
					pass = (solo_total != 0) ? solo_on[k] : !mute_on[k];
					if (pass)
						for (int o = 0; o < nout; o++)
							acc[o] = saturate(acc[o] + apply_gain(s, gain_q15[o][k]));
				end
			end
			CMD_SET_GAIN: begin
				if (k < nsrc && j < nout)
					gain_q15[j][k] = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
			end
			CMD_SOLO: begin
				if (k < nsrc) begin
					solo_on[k] = !solo_on[k];
					if (solo_on[k])
						solo_total++;
					else if (solo_total > 0)
						solo_total--;
				end
			end
			default: begin
				if (k < nsrc)
					mute_on[k] = !mute_on[k];
			end
		endcase
		// frame end acts after the command, whatever it was
		if (eof) begin
			for (int o = 0; o < nout; o++) begin
				r.chan = IDX_W'(o);
				r.value = SAMPLE_W'(saturate(acc[o]));
				r.last = (o + 1 == nout);
				owed.push_back(r);
			end
			for (int o = 0; o < LANES; o++)
				acc[o] = 0;
		end
	endfunction

	// Accepted output transaction against the oldest owed channel
	function void check_channel(logic [IDX_W-1:0] chan, logic [SAMPLE_W-1:0] value,
			logic last);
		mix_result_t e;
		if (owed.size() == 0) begin
			flag($sformatf("unexpected output: channel %0d value %0d last %0b",
				chan, $signed(value), last));
			return;
		end
		e = owed.pop_front();
		if (chan !== e.chan || value !== e.value || last !== e.last)
			flag($sformatf("exp channel %0d value %0d last %0b, got channel %0d value %0d last %0b",
				e.chan, $signed(e.value), e.last, chan, $signed(value), last));
	endfunction
endclass

module tb;
	localparam int LIMIT       = 200000;
	localparam int DRAIN_WAIT  = 20;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] command;
	logic [IDX_W-1:0] source_index;
	logic [IDX_W-1:0] output_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [GAIN_IN_W-1:0] gain_value;
	logic end_of_frame;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [IDX_W-1:0] channel;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic last_of_frame;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	mix_scoreboard sb = new();

	gain_matrix_audio_mixer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.source_index(source_index),
		.output_index(output_index),
		.sample_value(sample_value),
		.gain_value(gain_value),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.channel(channel),
		.mixed_sample(mixed_sample),
		.last_of_frame(last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stall: random, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Monitors
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_command(command, source_index, output_index, sample_value,
				gain_value, end_of_frame);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_channel(channel, mixed_sample, last_of_frame);
	end

	// One input transaction; returns at the falling edge after acceptance
	task automatic send(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] k, logic [IDX_W-1:0] j,
			logic signed [SAMPLE_W-1:0] value, logic [GAIN_IN_W-1:0] gain, logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command <= cmd;
		source_index <= k;
		output_index <= j;
		sample_value <= value;
		gain_value <= gain;
		end_of_frame <= eof;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Wait until every owed output has drained and the pipeline is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Mostly in-range samples with random content, plus gain writes and toggles
	task automatic send_random(int eof_pct);
		int r;
		int span;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] k;
		logic signed [SAMPLE_W-1:0] v;
		logic [GAIN_IN_W-1:0] g;
		r = $urandom_range(99);
		cmd = (r < 70) ? CMD_SAMPLE : (r < 82) ? CMD_SET_GAIN : (r < 91) ? CMD_MUTE : CMD_SOLO;
		span = sb.unity_cfg ? sb.n_out_cfg : sb.n_src_cfg;
		if (span > LANES)
			span = LANES;
		if (span == 0)
			span = 1;
		k = ($urandom_range(99) < 85) ? $urandom_range(span - 1) : $urandom_range(LANES - 1);
		r = $urandom_range(99);
		if (r < 8) begin
			v = $urandom;
		end else if (r < 14) begin
			// format extremes
			v = SAMPLE_W'(sb.saturate(r[0] ? 64'sh7fffffffffff : -64'sh7fffffffffff));
		end else begin
			case (sb.fmt_cfg)
				FMT_S8:  v = $urandom_range(255) - 128;
				FMT_S16: v = $urandom_range(65535) - 32768;
				default: v = $urandom;
			endcase
		end
		g = ($urandom_range(99) < 80) ? $urandom_range(UNITY_GAIN) : $urandom;
		send(cmd, k, $urandom_range(LANES - 1), v, g, $urandom_range(99) < eof_pct);
	endtask

	task automatic run_phase(int idle, int stall, int nout, int nsrc,
			logic [FMT_W-1:0] fmt, logic unity, int items, int eof_pct, bit hold);
		set_reg(CFG_OUTPUT_COUNT, nout);
		set_reg(CFG_SOURCE_COUNT, nsrc);
		set_reg(CFG_SAMPLE_FORMAT, fmt);
		set_reg(CFG_UNITY_MODE, unity);
		send_idle_pct = idle;
		stall_pct = stall;
		if (hold)
			hold_req++;
		repeat (items) send_random(eof_pct);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_OUTPUT_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_SAMPLE;
		source_index = '0;
		output_index = '0;
		sample_value = '0;
		gain_value = '0;
		end_of_frame = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset defaults: gains are zero, so the first frame is silent
		send(CMD_SAMPLE, 0, 0, 1234, 0, 1);
		send(CMD_SET_GAIN, 0, 0, 0, UNITY_GAIN, 0);
		send(CMD_SET_GAIN, 0, 1, 0, 16'hffff, 0);      // above unity, clipped
		send(CMD_SET_GAIN, 1, 1, 0, 16'd16384, 0);
		send(CMD_SET_GAIN, 1, 0, 0, 16'd1, 0);
		send(CMD_SAMPLE, 0, 0, 32767, 0, 0);
		send(CMD_SAMPLE, 1, 0, -32768, 0, 1);
		send(CMD_SAMPLE, 0, 0, 32767, 0, 0);
		send(CMD_SAMPLE, 0, 0, 32767, 0, 1);           // sum saturates high
		send(CMD_SAMPLE, 0, 0, -40000, 0, 1);          // sample outside format
		send(CMD_SET_GAIN, 0, 2, 0, 100, 0);           // output row out of range
		send(CMD_SET_GAIN, 5, 0, 0, 100, 0);           // source out of range
		send(CMD_SAMPLE, 5, 0, 999, 0, 1);
		send(CMD_MUTE, 0, 0, 0, 0, 0);
		send(CMD_SAMPLE, 0, 0, 100, 0, 0);
		send(CMD_SAMPLE, 1, 0, -100, 0, 1);
		send(CMD_SOLO, 0, 0, 0, 0, 0);                 // solo overrides mute
		send(CMD_SAMPLE, 0, 0, 500, 0, 0);
		send(CMD_SAMPLE, 1, 0, 500, 0, 1);
		send(CMD_SOLO, 0, 0, 0, 0, 1);                 // frame end on a toggle
		send(CMD_MUTE, 0, 0, 0, 0, 0);

		// Solo flag left behind a lowered source count still gates
		send(CMD_SOLO, 1, 0, 0, 0, 0);
		set_reg(CFG_SOURCE_COUNT, 1);
		send(CMD_SAMPLE, 0, 0, 300, 0, 1);
		set_reg(CFG_SOURCE_COUNT, 2);
		send(CMD_SOLO, 1, 0, 0, 0, 0);

		// 8-bit saturation
		set_reg(CFG_SAMPLE_FORMAT, FMT_S8);
		send(CMD_SAMPLE, 0, 0, 100, 0, 0);
		send(CMD_SAMPLE, 0, 0, 100, 0, 1);

		// Unity copy ignores gain and gating, indexed by output count
		set_reg(CFG_UNITY_MODE, 1);
		set_reg(CFG_OUTPUT_COUNT, 3);
		send(CMD_MUTE, 1, 0, 0, 0, 0);
		send(CMD_SAMPLE, 1, 0, -300, 0, 0);
		send(CMD_SAMPLE, 2, 0, 77, 0, 0);
		send(CMD_SAMPLE, 5, 0, 55, 0, 1);
		send(CMD_MUTE, 1, 0, 0, 0, 0);

		// Count extremes and the spare format code
		set_reg(CFG_UNITY_MODE, 0);
		set_reg(CFG_OUTPUT_COUNT, 0);
		send(CMD_SAMPLE, 0, 0, 10, 0, 1);              // emits nothing
		set_reg(CFG_OUTPUT_COUNT, 15);
		set_reg(CFG_SOURCE_COUNT, 0);
		send(CMD_SAMPLE, 0, 0, 10, 0, 1);
		set_reg(CFG_SAMPLE_FORMAT, FMT_WIDE_CODE);
		set_reg(CFG_SOURCE_COUNT, 12);
		send(CMD_SAMPLE, 0, 0, 32'sh80000000, 0, 1);

		// Random phases with differing idling
		run_phase(0, 0, 8, 8, FMT_S32, 0, 50, 15, 0);
		run_phase(50, 0, 3, 7, FMT_S8, 0, 36, 20, 0);
		run_phase(0, 50, 8, 8, FMT_S16, 1, 30, 20, 0);
		run_phase(10, 10, 15, 12, FMT_WIDE_CODE, 0, 32, 15, 0);
		// Long receiver hold-off while frames keep coming
		run_phase(0, 0, 8, 8, FMT_S16, 0, 28, 50, 1);

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
